### rtl/core/aeps_pkg.sv
`timescale 1ns / 1ps

package aeps_pkg;

  // Fixed-point format shared by d, d^p, alphas and the blend weight.
  localparam int FRAC = 16;
  localparam logic [16:0] ONE = 17'h10000;

  // Channel layout: translations first, then rotations.
  localparam int CH_N = 6;
  localparam logic [2:0] CH_LAST = 3'd5;
  localparam logic [2:0] TRANS_N = 3'd3;

  // Register map indexes (byte address = 4 * index).
  localparam logic [2:0] REG_MIN_SMOOTHING     = 3'd0;
  localparam logic [2:0] REG_SMOOTHING_RANGE   = 3'd1;
  localparam logic [2:0] REG_CURVE_EXPONENT    = 3'd2;
  localparam logic [2:0] REG_ALPHA_BLEND       = 3'd3;
  localparam logic [2:0] REG_TRANSLATION_SCALE = 3'd4;
  localparam logic [2:0] REG_ROTATION_SCALE    = 3'd5;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] target_yaw;
    logic signed [31:0] target_pitch;
    logic signed [31:0] target_roll;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_yaw;
    logic signed [31:0] out_pitch;
    logic signed [31:0] out_roll;
  } out_t;

  typedef struct packed {
    logic [7:0]  min_smoothing;
    logic [7:0]  smoothing_range;
    logic [5:0]  curve_exponent;
    logic [16:0] alpha_blend;
    logic [30:0] translation_scale;
    logic [30:0] rotation_scale;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_IDLE,
    OP_MUL,
    OP_DIV_LOAD,
    OP_DIV_STEP
  } alu_op_e;

  typedef struct packed {
    alu_op_e            op;
    logic signed [33:0] mul_a;
    logic signed [17:0] mul_b;
    logic [31:0]        div_rem;
    logic [31:0]        div_d;
  } alu_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DELTA,
    S_DDIV,
    S_DSET,
    S_POW,
    S_DEN,
    S_DEN2,
    S_ADIV,
    S_ASET,
    S_BL1,
    S_BL2,
    S_BL3,
    S_OMUL,
    S_OADD,
    S_DONE
  } state_e;

endpackage

### rtl/core/adaptive_ewma_pose_smoother_core.sv
`timescale 1ns / 1ps

// Adaptive exponential smoother for a six-channel pose (x, y, z, yaw, pitch, roll).
// Input channel: in_valid/in_ready with one target pose per transfer. Output
// channel: out_valid/out_ready with one smoothed pose per input transfer.
// Settings sit behind the APB port and are to be written only while the block is
// idle; the block itself does not enforce this. The first transfer after reset
// passes through: the sequencer goes straight to its done state and loads the
// output register from that pose. Every later item walks the six channels through
// one shared multiplier and one bit-serial divider: per channel a delta step, a
// 16-step divide and a set step for the normalized movement, p multiplies for the
// power (p = curve_exponent), the denominator states S_DEN and S_DEN2, a 16-step
// divide and a set step for alpha and the blend states S_BL1 to S_BL3, then a
// multiply and an add per channel to apply the largest alpha. A channel whose
// movement saturates or whose alpha clamps skips that divide and its set step.
// in_ready is high only while the sequencer is idle. A finished pose sits in the
// output register; if the receiver stalls, the next item may still be taken and
// is held at its end until the register frees. Reset restores the register
// defaults, empties the output register and arms the pass-through of the next item.

module adaptive_ewma_pose_smoother_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  aeps_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output aeps_pkg::out_t      out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  aeps_pkg::cfg_t     cfg;
  aeps_pkg::alu_ctl_t ctl;
  aeps_pkg::state_e   state, state_next;

  logic signed [51:0] prod;
  logic [15:0]        quot;

  aeps_pkg::in_t      tgt;
  logic signed [31:0] last_out   [aeps_pkg::CH_N];
  logic [16:0]        last_alpha [aeps_pkg::CH_N];
  logic signed [32:0] delta      [aeps_pkg::CH_N];
  logic               first_pend;
  logic [2:0]         ch;
  logic [5:0]         cnt;
  logic [16:0]        d_r;
  logic [16:0]        alpha_r;
  logic [33:0]        acc;
  logic [16:0]        largest;

  logic signed [31:0] tgt_c;
  logic signed [32:0] delta_c;
  logic [32:0]        mag;
  logic [30:0]        scale_raw;
  logic [30:0]        sc;
  logic               big;
  logic [16:0]        blend;
  logic [16:0]        dp_c;
  logic [16:0]        pow_a;
  logic [24:0]        den_c;
  logic [33:0]        sum_c;
  logic [16:0]        s_c;
  logic signed [31:0] out_new;
  logic               in_xfer;
  logic               out_load;

  aeps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  aeps_alu u_alu (
    .clk  (clk),
    .ctl  (ctl),
    .prod (prod),
    .quot (quot)
  );

  // Target of the current channel.
  always_comb begin
    case (ch)
      3'd0:    tgt_c = tgt.target_x;
      3'd1:    tgt_c = tgt.target_y;
      3'd2:    tgt_c = tgt.target_z;
      3'd3:    tgt_c = tgt.target_yaw;
      3'd4:    tgt_c = tgt.target_pitch;
      default: tgt_c = tgt.target_roll;
    endcase
  end

  // Per-channel datapath terms.
  always_comb begin
    delta_c   = 33'(tgt_c) - 33'(last_out[ch]);
    mag       = delta_c[32] ? 33'(-delta_c) : 33'(delta_c);
    scale_raw = (ch < aeps_pkg::TRANS_N) ? cfg.translation_scale : cfg.rotation_scale;
    sc        = (scale_raw == 31'd0) ? 31'd1 : scale_raw;
    big       = mag >= {2'b00, sc};
    blend     = (cfg.alpha_blend > aeps_pkg::ONE) ? aeps_pkg::ONE : cfg.alpha_blend;
    dp_c      = (cfg.curve_exponent == 6'd0) ? aeps_pkg::ONE : prod[32:16];
    pow_a     = (cnt == 6'd0) ? aeps_pkg::ONE : prod[32:16];
    den_c     = 25'({cfg.min_smoothing, 16'd0}) + prod[24:0];
    sum_c     = acc + prod[33:0];
    s_c       = sum_c[32:16];
    out_new   = last_out[ch] + prod[47:16];
  end

  assign in_xfer  = in_valid && in_ready;
  assign out_load = (state == aeps_pkg::S_DONE) && (!out_valid || out_ready);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      aeps_pkg::S_IDLE:
        if (in_valid) begin
          state_next = first_pend ? aeps_pkg::S_DONE : aeps_pkg::S_DELTA;
        end
      aeps_pkg::S_DELTA: state_next = big ? aeps_pkg::S_POW : aeps_pkg::S_DDIV;
      aeps_pkg::S_DDIV:
        if (cnt == 6'd15) begin
          state_next = aeps_pkg::S_DSET;
        end
      aeps_pkg::S_DSET: state_next = aeps_pkg::S_POW;
      aeps_pkg::S_POW:
        if (cfg.curve_exponent == 6'd0 || cnt == cfg.curve_exponent) begin
          state_next = aeps_pkg::S_DEN;
        end
      aeps_pkg::S_DEN:  state_next = aeps_pkg::S_DEN2;
      aeps_pkg::S_DEN2:
        state_next = (den_c > 25'(aeps_pkg::ONE)) ? aeps_pkg::S_ADIV : aeps_pkg::S_BL1;
      aeps_pkg::S_ADIV:
        if (cnt == 6'd15) begin
          state_next = aeps_pkg::S_ASET;
        end
      aeps_pkg::S_ASET: state_next = aeps_pkg::S_BL1;
      aeps_pkg::S_BL1:  state_next = aeps_pkg::S_BL2;
      aeps_pkg::S_BL2:  state_next = aeps_pkg::S_BL3;
      aeps_pkg::S_BL3:
        state_next = (ch == aeps_pkg::CH_LAST) ? aeps_pkg::S_OMUL : aeps_pkg::S_DELTA;
      aeps_pkg::S_OMUL: state_next = aeps_pkg::S_OADD;
      aeps_pkg::S_OADD:
        state_next = (ch == aeps_pkg::CH_LAST) ? aeps_pkg::S_DONE : aeps_pkg::S_OMUL;
      aeps_pkg::S_DONE:
        if (out_load) begin
          state_next = aeps_pkg::S_IDLE;
        end
      default: state_next = aeps_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and shared unit commands.
  always_comb begin
    in_ready    = 1'b0;
    ctl.op      = aeps_pkg::OP_IDLE;
    ctl.mul_a   = 34'sd0;
    ctl.mul_b   = 18'sd0;
    ctl.div_rem = 32'd0;
    ctl.div_d   = 32'd0;
    case (state)
      aeps_pkg::S_IDLE: in_ready = 1'b1;
      aeps_pkg::S_DELTA:
        if (!big) begin
          ctl.op      = aeps_pkg::OP_DIV_LOAD;
          ctl.div_rem = mag[31:0];
          ctl.div_d   = {1'b0, sc};
        end
      aeps_pkg::S_DDIV, aeps_pkg::S_ADIV: ctl.op = aeps_pkg::OP_DIV_STEP;
      aeps_pkg::S_POW:
        if (cfg.curve_exponent != 6'd0 && cnt != cfg.curve_exponent) begin
          ctl.op    = aeps_pkg::OP_MUL;
          ctl.mul_a = 34'(pow_a);
          ctl.mul_b = 18'(d_r);
        end
      aeps_pkg::S_DEN: begin
        ctl.op    = aeps_pkg::OP_MUL;
        ctl.mul_a = 34'(aeps_pkg::ONE - dp_c);
        ctl.mul_b = 18'(cfg.smoothing_range);
      end
      aeps_pkg::S_DEN2:
        if (den_c > 25'(aeps_pkg::ONE)) begin
          ctl.op      = aeps_pkg::OP_DIV_LOAD;
          ctl.div_rem = 32'(aeps_pkg::ONE);
          ctl.div_d   = 32'(den_c);
        end
      aeps_pkg::S_BL1: begin
        ctl.op    = aeps_pkg::OP_MUL;
        ctl.mul_a = 34'(blend);
        ctl.mul_b = 18'(alpha_r);
      end
      aeps_pkg::S_BL2: begin
        ctl.op    = aeps_pkg::OP_MUL;
        ctl.mul_a = 34'(aeps_pkg::ONE - blend);
        ctl.mul_b = 18'(last_alpha[ch]);
      end
      aeps_pkg::S_OMUL: begin
        ctl.op    = aeps_pkg::OP_MUL;
        ctl.mul_a = 34'(delta[ch]);
        ctl.mul_b = 18'(largest);
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= aeps_pkg::S_IDLE;
      first_pend <= 1'b1;
      out_valid  <= 1'b0;
      ch         <= 3'd0;
      cnt        <= 6'd0;
    end else begin
      state <= state_next;
      if (in_xfer) begin
        first_pend <= 1'b0;
        ch         <= 3'd0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        aeps_pkg::S_DELTA, aeps_pkg::S_DSET, aeps_pkg::S_DEN2: cnt <= 6'd0;
        aeps_pkg::S_DDIV, aeps_pkg::S_ADIV: cnt <= cnt + 6'd1;
        aeps_pkg::S_POW:
          if (cnt != cfg.curve_exponent) begin
            cnt <= cnt + 6'd1;
          end
        aeps_pkg::S_BL3, aeps_pkg::S_OADD:
          ch <= (ch == aeps_pkg::CH_LAST) ? 3'd0 : ch + 3'd1;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tgt     <= in_data;
      largest <= 17'd0;
      if (first_pend) begin
        last_out[0] <= in_data.target_x;
        last_out[1] <= in_data.target_y;
        last_out[2] <= in_data.target_z;
        last_out[3] <= in_data.target_yaw;
        last_out[4] <= in_data.target_pitch;
        last_out[5] <= in_data.target_roll;
        for (int i = 0; i < aeps_pkg::CH_N; i++) begin
          last_alpha[i] <= 17'd0;
        end
      end
    end
    case (state)
      aeps_pkg::S_DELTA: begin
        delta[ch] <= delta_c;
        if (big) begin
          d_r <= aeps_pkg::ONE;
        end
      end
      aeps_pkg::S_DSET: d_r <= {1'b0, quot};
      aeps_pkg::S_DEN2:
        if (!(den_c > 25'(aeps_pkg::ONE))) begin
          alpha_r <= aeps_pkg::ONE;
        end
      aeps_pkg::S_ASET: alpha_r <= {1'b0, quot};
      aeps_pkg::S_BL2:  acc <= prod[33:0];
      aeps_pkg::S_BL3: begin
        last_alpha[ch] <= s_c;
        if (s_c >= largest) begin
          largest <= s_c;
        end
      end
      aeps_pkg::S_OADD: last_out[ch] <= out_new;
      default: ;
    endcase
    // Fill the output register from the stored pose.
    if (out_load) begin
      out_data.out_x     <= last_out[0];
      out_data.out_y     <= last_out[1];
      out_data.out_z     <= last_out[2];
      out_data.out_yaw   <= last_out[3];
      out_data.out_pitch <= last_out[4];
      out_data.out_roll  <= last_out[5];
    end
  end

endmodule

### rtl/core/aeps_cfg.sv
`timescale 1ns / 1ps

module aeps_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output aeps_pkg::cfg_t    cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;

  // Register writes; indexes beyond the map are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_smoothing     <= 8'd15;
      cfg.smoothing_range   <= 8'd35;
      cfg.curve_exponent    <= 6'd10;
      cfg.alpha_blend       <= 17'd1311;
      cfg.translation_scale <= 31'd1638;
      cfg.rotation_scale    <= 31'd393216;
    end else if (wr_en) begin
      case (idx)
        aeps_pkg::REG_MIN_SMOOTHING:     cfg.min_smoothing     <= pwdata[7:0];
        aeps_pkg::REG_SMOOTHING_RANGE:   cfg.smoothing_range   <= pwdata[7:0];
        aeps_pkg::REG_CURVE_EXPONENT:    cfg.curve_exponent    <= pwdata[5:0];
        aeps_pkg::REG_ALPHA_BLEND:       cfg.alpha_blend       <= pwdata[16:0];
        aeps_pkg::REG_TRANSLATION_SCALE: cfg.translation_scale <= pwdata[30:0];
        aeps_pkg::REG_ROTATION_SCALE:    cfg.rotation_scale    <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (idx)
      aeps_pkg::REG_MIN_SMOOTHING:     prdata = 32'(cfg.min_smoothing);
      aeps_pkg::REG_SMOOTHING_RANGE:   prdata = 32'(cfg.smoothing_range);
      aeps_pkg::REG_CURVE_EXPONENT:    prdata = 32'(cfg.curve_exponent);
      aeps_pkg::REG_ALPHA_BLEND:       prdata = 32'(cfg.alpha_blend);
      aeps_pkg::REG_TRANSLATION_SCALE: prdata = 32'(cfg.translation_scale);
      aeps_pkg::REG_ROTATION_SCALE:    prdata = 32'(cfg.rotation_scale);
      default:                         prdata = 32'd0;
    endcase
  end

endmodule

### rtl/core/aeps_alu.sv
`timescale 1ns / 1ps

module aeps_alu (
  input  logic                  clk,
  input  aeps_pkg::alu_ctl_t    ctl,
  output logic signed [51:0]    prod,
  output logic [15:0]           quot
);

  logic [31:0] rem;
  logic [31:0] dvs;
  logic [32:0] rem_sh;
  logic        ge;

  // One restoring division step: shift in a zero and try the subtract.
  assign rem_sh = {rem, 1'b0};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    case (ctl.op)
      aeps_pkg::OP_MUL: begin
        prod <= ctl.mul_a * ctl.mul_b;
      end
      aeps_pkg::OP_DIV_LOAD: begin
        rem  <= ctl.div_rem;
        dvs  <= ctl.div_d;
        quot <= 16'd0;
      end
      aeps_pkg::OP_DIV_STEP: begin
        if (ge) begin
          rem <= 32'(rem_sh - {1'b0, dvs});
        end else begin
          rem <= rem_sh[31:0];
        end
        quot <= {quot[14:0], ge};
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/aeps_checker.sv
`timescale 1ns / 1ps

module aeps_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input aeps_pkg::out_t out_data,
  input logic           pready
);

  // The sequencer is busy right after taking an item.
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after an input transfer");

  // A result never appears in the cycle right after an input transfer.
  a_no_instant_out: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("output valid rose one cycle after an input transfer");

  // A stalled result is held.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled output dropped or changed");

  // The register port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind adaptive_ewma_pose_smoother_core aeps_checker u_aeps_checker (.*);

### tb/tb_adaptive_ewma_pose_smoother_core.sv
`timescale 1ns / 1ps

module tb_adaptive_ewma_pose_smoother_core;

  localparam int ONE_I = 65536;
  localparam int MAX_CYCLES = 3000000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  aeps_pkg::in_t in_data;
  logic out_valid;
  logic out_ready;
  aeps_pkg::out_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  adaptive_ewma_pose_smoother_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the smoother's settings and history.
  aeps_pkg::cfg_t shadow_cfg;
  logic signed [31:0] prev_pose [aeps_pkg::CH_N];
  logic [16:0] shadow_alpha [aeps_pkg::CH_N];
  logic prime_pending;

  aeps_pkg::out_t pending_poses[$];
  int errors;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  logic hold_off;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycle counter bounds the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("adaptive_ewma_pose_smoother_core: mismatch");
      $finish;
    end
  end

  function automatic void reset_shadow();
    shadow_cfg.min_smoothing = 8'd15;
    shadow_cfg.smoothing_range = 8'd35;
    shadow_cfg.curve_exponent = 6'd10;
    shadow_cfg.alpha_blend = 17'd1311;
    shadow_cfg.translation_scale = 31'd1638;
    shadow_cfg.rotation_scale = 31'd393216;
    for (int i = 0; i < aeps_pkg::CH_N; i++) begin
      prev_pose[i] = '0;
      shadow_alpha[i] = '0;
    end
    prime_pending = 1'b1;
  endfunction

  // Raw alpha for one channel from its movement and group scale.
  function automatic logic [63:0] raw_alpha(longint mv, logic [30:0] scale);
    logic [63:0] mag;
    logic [63:0] sc;
    logic [63:0] d;
    logic [63:0] dp;
    logic [63:0] den;
    logic [63:0] a;
    mag = (mv < 0) ? 64'(-mv) : 64'(mv);
    sc = (scale == 0) ? 64'd1 : 64'(scale);
    d = (mag << aeps_pkg::FRAC) / sc;
    if (d > 64'(ONE_I)) d = 64'(ONE_I);
    dp = 64'(ONE_I);
    for (int k = 0; k < shadow_cfg.curve_exponent; k++) dp = (dp * d) >> aeps_pkg::FRAC;
    den = (64'(shadow_cfg.min_smoothing) << aeps_pkg::FRAC) +
          (64'(ONE_I) - dp) * 64'(shadow_cfg.smoothing_range);
    if (den == 0) return 64'(ONE_I);
    a = (64'(ONE_I) * 64'(ONE_I)) / den;
    return (a > 64'(ONE_I)) ? 64'(ONE_I) : a;
  endfunction

  // Smoothed pose for one target; updates the shadow history.
  function automatic aeps_pkg::out_t smooth_pose(aeps_pkg::in_t tgt);
    logic signed [31:0] t [aeps_pkg::CH_N];
    longint mv [aeps_pkg::CH_N];
    logic [63:0] blend;
    logic [63:0] s;
    logic [63:0] largest;
    longint prod;
    longint v;
    aeps_pkg::out_t r;
    t[0] = tgt.target_x; t[1] = tgt.target_y; t[2] = tgt.target_z;
    t[3] = tgt.target_yaw; t[4] = tgt.target_pitch; t[5] = tgt.target_roll;
    if (prime_pending) begin
      for (int i = 0; i < aeps_pkg::CH_N; i++) begin
        prev_pose[i] = t[i];
        shadow_alpha[i] = '0;
      end
      prime_pending = 1'b0;
    end else begin
      blend = (shadow_cfg.alpha_blend > ONE_I) ? 64'(ONE_I) : 64'(shadow_cfg.alpha_blend);
      largest = '0;
      for (int i = 0; i < aeps_pkg::CH_N; i++) begin
        mv[i] = longint'(t[i]) - longint'(prev_pose[i]);
        s = (blend * raw_alpha(mv[i], (i < aeps_pkg::TRANS_N) ? shadow_cfg.translation_scale
                                                              : shadow_cfg.rotation_scale) +
             (64'(ONE_I) - blend) * 64'(shadow_alpha[i])) >> aeps_pkg::FRAC;
        shadow_alpha[i] = s[16:0];
        if (s >= largest) largest = s;
      end
      for (int i = 0; i < aeps_pkg::CH_N; i++) begin
        // Arithmetic shift floors toward minus infinity.
        prod = longint'(largest) * mv[i];
        v = longint'(prev_pose[i]) + (prod >>> aeps_pkg::FRAC);
        prev_pose[i] = v[31:0];
      end
    end
    r.out_x = prev_pose[0]; r.out_y = prev_pose[1]; r.out_z = prev_pose[2];
    r.out_yaw = prev_pose[3]; r.out_pitch = prev_pose[4]; r.out_roll = prev_pose[5];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Output side: random stalls, one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_poses.size() == 0) begin
          $error("pose arrived with none expected");
          errors++;
        end else begin
          aeps_pkg::out_t e;
          e = pending_poses.pop_front();
          check_field("out_x", e.out_x, out_data.out_x);
          check_field("out_y", e.out_y, out_data.out_y);
          check_field("out_z", e.out_z, out_data.out_z);
          check_field("out_yaw", e.out_yaw, out_data.out_yaw);
          check_field("out_pitch", e.out_pitch, out_data.out_pitch);
          check_field("out_roll", e.out_roll, out_data.out_roll);
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver stall counted here while the sender keeps offering.
  initial begin
    hold_off = 1'b0;
    wait (cycle_count > 40000);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      aeps_pkg::REG_MIN_SMOOTHING:     shadow_cfg.min_smoothing = val[7:0];
      aeps_pkg::REG_SMOOTHING_RANGE:   shadow_cfg.smoothing_range = val[7:0];
      aeps_pkg::REG_CURVE_EXPONENT:    shadow_cfg.curve_exponent = val[5:0];
      aeps_pkg::REG_ALPHA_BLEND:       shadow_cfg.alpha_blend = val[16:0];
      aeps_pkg::REG_TRANSLATION_SCALE: shadow_cfg.translation_scale = val[30:0];
      aeps_pkg::REG_ROTATION_SCALE:    shadow_cfg.rotation_scale = val[30:0];
      default: ;
    endcase
  endtask

  // Drop valid after the last transfer, then wait for every pose to come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // One input transfer; the expectation is queued at acceptance. Valid stays
  // up after a transfer until the next pose or an idle cycle replaces it.
  task automatic send_pose(aeps_pkg::in_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_poses.push_back(smooth_pose(p));
  endtask

  function automatic aeps_pkg::in_t pose_all(logic [31:0] v);
    aeps_pkg::in_t p;
    p = {6{v}};
    return p;
  endfunction

  // Random pose near the last target, sometimes a jump or full noise.
  function automatic aeps_pkg::in_t near_pose(aeps_pkg::in_t base);
    aeps_pkg::in_t p;
    int mode;
    logic [31:0] f [6];
    logic [31:0] b [6];
    mode = $urandom_range(9);
    b = '{base.target_x, base.target_y, base.target_z,
          base.target_yaw, base.target_pitch, base.target_roll};
    for (int i = 0; i < 6; i++) begin
      if (mode == 0) f[i] = $urandom;
      else if (mode < 4) f[i] = b[i] + $urandom_range(4000000) - 2000000;
      else f[i] = b[i] + $urandom_range(4000) - 2000;
    end
    p = {f[0], f[1], f[2], f[3], f[4], f[5]};
    return p;
  endfunction

  typedef struct {
    aeps_pkg::in_t pose;
    logic known;
    aeps_pkg::out_t result;
  } stim_row_t;

  initial begin
    stim_row_t rows [$];
    aeps_pkg::in_t cur;
    stim_row_t row;
    cycle_count = 0;
    errors = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    reset_shadow();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: first item passes through, then extremes and a repeat.
    row.pose = pose_all(32'h8000_0000); row.known = 1'b1;
    row.result = aeps_pkg::out_t'(pose_all(32'h8000_0000)); rows.push_back(row);
    row.known = 1'b0;
    row.pose = pose_all(32'h8000_0000); rows.push_back(row);
    row.pose = pose_all(32'h7fff_ffff); rows.push_back(row);
    row.pose = pose_all(32'h0000_0000); rows.push_back(row);
    row.pose = pose_all(32'hffff_ffff); rows.push_back(row);
    row.pose = {32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'hffff_0000, 32'h5555_5555,
                32'haaaa_aaaa};
    rows.push_back(row);
    row.pose = pose_all(32'h0000_0010); rows.push_back(row);
    send_idle_pct = 36; recv_idle_pct = 45;
    foreach (rows[i]) begin
      if (rows[i].known) begin
        send_pose(rows[i].pose);
        void'(pending_poses.pop_back());
        pending_poses.push_back(rows[i].result);
      end else begin
        send_pose(rows[i].pose);
      end
    end
    drain();

    // Extreme settings: zero scales, zero exponent, zero denominator, blend above one.
    apb_write(aeps_pkg::REG_MIN_SMOOTHING, 32'd255);
    apb_write(aeps_pkg::REG_SMOOTHING_RANGE, 32'd255);
    apb_write(aeps_pkg::REG_CURVE_EXPONENT, 32'd0);
    apb_write(aeps_pkg::REG_ALPHA_BLEND, 32'h1ffff);
    apb_write(aeps_pkg::REG_TRANSLATION_SCALE, 32'd0);
    apb_write(aeps_pkg::REG_ROTATION_SCALE, 32'h7fff_ffff);
    cur = pose_all(32'h0001_0000);
    for (int i = 0; i < 6; i++) begin
      cur = near_pose(cur); send_pose(cur);
    end
    drain();
    apb_write(aeps_pkg::REG_MIN_SMOOTHING, 32'd0);
    apb_write(aeps_pkg::REG_SMOOTHING_RANGE, 32'd0);
    apb_write(aeps_pkg::REG_CURVE_EXPONENT, 32'd63);
    apb_write(aeps_pkg::REG_ALPHA_BLEND, 32'd0);
    apb_write(aeps_pkg::REG_TRANSLATION_SCALE, 32'h7fff_ffff);
    apb_write(aeps_pkg::REG_ROTATION_SCALE, 32'd0);
    for (int i = 0; i < 6; i++) begin
      cur = near_pose(cur); send_pose(cur);
    end
    drain();

    // Random phases with a fresh setting each; idling pattern follows phase.
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 36; recv_idle_pct = 45;
      end else if (ph < 6) begin
        send_idle_pct = 45; recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (ph == 8) begin
        apb_write(aeps_pkg::REG_MIN_SMOOTHING, 32'd15);
        apb_write(aeps_pkg::REG_SMOOTHING_RANGE, 32'd35);
        apb_write(aeps_pkg::REG_CURVE_EXPONENT, 32'd10);
        apb_write(aeps_pkg::REG_ALPHA_BLEND, 32'd1311);
        apb_write(aeps_pkg::REG_TRANSLATION_SCALE, 32'd1638);
        apb_write(aeps_pkg::REG_ROTATION_SCALE, 32'd393216);
      end else begin
        apb_write(aeps_pkg::REG_MIN_SMOOTHING, $urandom_range(255, 1));
        apb_write(aeps_pkg::REG_SMOOTHING_RANGE, $urandom_range(255));
        apb_write(aeps_pkg::REG_CURVE_EXPONENT, $urandom_range(12, 1));
        apb_write(aeps_pkg::REG_ALPHA_BLEND, $urandom_range(65536));
        apb_write(aeps_pkg::REG_TRANSLATION_SCALE, $urandom_range(2000000, 1));
        apb_write(aeps_pkg::REG_ROTATION_SCALE,
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(8000000));
      end
      for (int n = 0; n < 98; n++) begin
        cur = near_pose(cur);
        send_pose(cur);
      end
      drain();
    end

    if (errors == 0) begin
      $display("adaptive_ewma_pose_smoother_core: match");
    end else begin
      $display("adaptive_ewma_pose_smoother_core: mismatch");
    end
    $finish;
  end

endmodule
